/* src/sorted_key_table_top_macros.svh */
// assertion macros for the sorted key table checker
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SKT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/skt_pkg.sv */
package skt_pkg;

  // fixed field widths
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int PL_W     = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 8;

  // table size default and merge group size
  localparam int DEPTH_DEFAULT = 128;
  localparam int GROUP         = 16;

  // operation codes, code three acts as a lookup
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } skt_op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_PRESENT = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } skt_status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_MERGE,
    S_APPLY
  } skt_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic cmp_en;
    logic merge_en;
    logic apply_en;
  } skt_cmd_t;

endpackage

/* src/skt_cmd_if.sv */
interface skt_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [skt_pkg::OP_W-1:0]            op;
  logic signed [skt_pkg::KEY_W-1:0]    key;
  logic [skt_pkg::PL_W-1:0]            payload;

  modport source (output valid, op, key, payload, input ready);
  modport sink   (input valid, op, key, payload, output ready);
endinterface

/* src/skt_rsp_if.sv */
interface skt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [skt_pkg::STATUS_W-1:0]  status;
  logic                          found;
  logic [skt_pkg::PL_W-1:0]      result_payload;
  logic [skt_pkg::OCC_W-1:0]     occupancy;

  modport source (output valid, status, found, result_payload, occupancy, input ready);
  modport sink   (input valid, status, found, result_payload, occupancy, output ready);
endinterface

/* src/skt_ctrl.sv */
module skt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output skt_pkg::skt_cmd_t dp_cmd
);
  import skt_pkg::*;

  skt_state_t state, state_next;
  logic       rsp_valid_next;

  // state and response valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    dp_cmd         = '0;
    cmd_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    case (state)
      S_IDLE: begin
        // no word is taken while reset is held
        cmd_ready = !rst;
        if (cmd_valid && !rst) begin
          dp_cmd.capture = 1'b1;
          state_next     = S_CMP;
        end
      end
      S_CMP: begin
        dp_cmd.cmp_en = 1'b1;
        state_next    = S_MERGE;
      end
      S_MERGE: begin
        dp_cmd.merge_en = 1'b1;
        state_next      = S_APPLY;
      end
      S_APPLY: begin
        // hold while the previous word still waits
        if (!rsp_valid || rsp_ready) begin
          dp_cmd.apply_en = 1'b1;
          rsp_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* src/skt_datapath.sv */
module skt_datapath #(
  parameter int DEPTH = skt_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  skt_pkg::skt_cmd_t                dp_cmd,
  input  logic [skt_pkg::OP_W-1:0]         op,
  input  logic signed [skt_pkg::KEY_W-1:0] key,
  input  logic [skt_pkg::PL_W-1:0]         payload,
  output logic [skt_pkg::STATUS_W-1:0]     status,
  output logic                             found,
  output logic [skt_pkg::PL_W-1:0]         result_payload,
  output logic [skt_pkg::OCC_W-1:0]        occupancy
);
  import skt_pkg::*;

  localparam int CW      = $clog2(DEPTH + 1);
  localparam int NUM_GRP = (DEPTH + GROUP - 1) / GROUP;

  // captured operation
  logic [OP_W-1:0]         op_q;
  logic signed [KEY_W-1:0] key_q;
  logic [PL_W-1:0]         pl_q;

  // cell chain
  logic signed [KEY_W-1:0] cell_key [DEPTH];
  logic [PL_W-1:0]         cell_pl  [DEPTH];
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;

  // per-cell compare results
  logic [DEPTH-1:0] gt_q;
  logic [DEPTH-1:0] eq_q;

  // merge group results
  logic [NUM_GRP-1:0] grp_hit;
  logic [PL_W-1:0]    grp_pl [NUM_GRP];
  logic [GROUP-1:0]   grp_eq [NUM_GRP];
  logic [PL_W-1:0]    grp_sel [NUM_GRP][GROUP];

  // final decision
  logic           hit;
  logic [PL_W-1:0] hit_pl;
  logic           full;
  logic           do_insert;
  logic           do_remove;
  skt_status_t    status_d;
  logic [PL_W-1:0] result_d;
  logic [CW+OCC_W-1:0] occ_ext;

  // capture the word
  always_ff @(posedge clk) begin
    if (dp_cmd.capture) begin
      op_q  <= op;
      key_q <= key;
      pl_q  <= payload;
    end
  end

  // compare every cell against the key
  for (genvar i = 0; i < DEPTH; i++) begin : g_cmp
    logic live;
    assign live = CW'(i) < count;
    always_ff @(posedge clk) begin
      if (dp_cmd.cmp_en) begin
        gt_q[i] <= live && (cell_key[i] > key_q);
        eq_q[i] <= live && (cell_key[i] == key_q);
      end
    end
  end

  // group slices of the match vector
  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    for (genvar j = 0; j < GROUP; j++) begin : g_slot
      if (g * GROUP + j < DEPTH) begin : g_real
        assign grp_eq[g][j]  = eq_q[g * GROUP + j];
        assign grp_sel[g][j] = eq_q[g * GROUP + j] ? cell_pl[g * GROUP + j] : '0;
      end else begin : g_pad
        assign grp_eq[g][j]  = 1'b0;
        assign grp_sel[g][j] = '0;
      end
    end

    // first merge level, registered
    always_ff @(posedge clk) begin
      if (dp_cmd.merge_en) begin
        grp_hit[g] <= |grp_eq[g];
        grp_pl[g]  <= grp_sel[g].or();
      end
    end
  end

  // second merge level
  always_comb begin
    hit_pl = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      hit_pl = hit_pl | grp_pl[g];
    end
  end

  assign hit  = |grp_hit;
  assign full = (count == CW'(DEPTH));

  // decide status and count
  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    result_d   = '0;
    status_d   = ST_DONE;
    count_next = count;
    case (op_q)
      OP_INSERT: begin
        if (hit) begin
          status_d = ST_PRESENT;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          do_insert  = 1'b1;
          count_next = count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          do_remove  = 1'b1;
          count_next = count - 1'b1;
        end else begin
          status_d = ST_MISSING;
        end
      end
      default: begin
        if (hit) begin
          result_d = hit_pl;
        end else begin
          status_d = ST_MISSING;
        end
      end
    endcase
  end

  // cell updates: insert shifts up above the key, remove shifts down from it
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic from_prev;
    logic take_new;
    logic from_next;
    if (i > 0) begin : g_prev
      assign from_prev = gt_q[i-1];
    end else begin : g_first
      assign from_prev = 1'b0;
    end
    assign take_new = (gt_q[i] || (CW'(i) == count)) && !from_prev;
    if (i < DEPTH - 1) begin : g_next
      assign from_next = gt_q[i] || eq_q[i];
    end else begin : g_last
      assign from_next = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (dp_cmd.apply_en && do_insert) begin
        if (from_prev) begin
          cell_key[i] <= cell_key[(i > 0) ? i - 1 : 0];
          cell_pl[i]  <= cell_pl[(i > 0) ? i - 1 : 0];
        end else if (take_new) begin
          cell_key[i] <= key_q;
          cell_pl[i]  <= pl_q;
        end
      end else if (dp_cmd.apply_en && do_remove && from_next) begin
        cell_key[i] <= cell_key[(i < DEPTH - 1) ? i + 1 : i];
        cell_pl[i]  <= cell_pl[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (dp_cmd.apply_en) begin
      count <= count_next;
    end
  end

  assign occ_ext = {{OCC_W{1'b0}}, count_next};

  // response word register
  always_ff @(posedge clk) begin
    if (dp_cmd.apply_en) begin
      status         <= status_d;
      found          <= hit;
      result_payload <= result_d;
      occupancy      <= occ_ext[OCC_W-1:0];
    end
  end

endmodule

/* src/sorted_key_table_top.sv */
// channel  dir  fields                                   handshake
// cmd      in   op, key, payload                         valid / ready
// rsp      out  status, found, result_payload, occupancy  valid / ready
//
// each word passes through accept, compare in every cell, group merge,
// then final merge with the table update
// reset clears the entry count and the controller, table cells are not cleared
// a new word is taken while a response waits; a stalled response holds the
// controller in its update step until the response is taken
module sorted_key_table_top #(
  parameter int DEPTH = skt_pkg::DEPTH_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  skt_cmd_if.sink   cmd,
  skt_rsp_if.source rsp
);
  import skt_pkg::*;

  skt_cmd_t dp_cmd;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .dp_cmd    (dp_cmd)
  );

  skt_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .dp_cmd         (dp_cmd),
    .op             (cmd.op),
    .key            (cmd.key),
    .payload        (cmd.payload),
    .status         (rsp.status),
    .found          (rsp.found),
    .result_payload (rsp.result_payload),
    .occupancy      (rsp.occupancy)
  );

endmodule

/* src/skt_checker.sv */
`include "sorted_key_table_top_macros.svh"

module skt_checker #(
  parameter int DEPTH = skt_pkg::DEPTH_DEFAULT
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input logic [skt_pkg::STATUS_W-1:0]    rsp_status,
  input logic                            rsp_found,
  input logic [skt_pkg::PL_W-1:0]        rsp_result_payload,
  input logic [skt_pkg::OCC_W-1:0]       rsp_occupancy
);
  import skt_pkg::*;

  // a waiting response stays up
  `SKT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

  // payload only on a successful match
  `SKT_ASSERT_NOW(a_pl_zero, rsp_valid && !(rsp_status == ST_DONE && rsp_found), rsp_result_payload == '0, "payload without a hit")

  // found agrees with the status code
  `SKT_ASSERT_NOW(a_found_status, rsp_valid && (rsp_status == ST_MISSING || rsp_status == ST_FULL), !rsp_found, "found set on a miss")

  // occupancy within the table size, checked for tables below 256 entries
  `SKT_ASSERT_NOW(a_occ_range, rsp_valid && (DEPTH < 256), int'(rsp_occupancy) <= DEPTH, "occupancy beyond table size")

endmodule

bind sorted_key_table_top skt_checker #(
  .DEPTH (DEPTH)
) u_skt_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found          (rsp.found),
  .rsp_result_payload (rsp.result_payload),
  .rsp_occupancy      (rsp.occupancy)
);
